FILE: design/lztsd_pkg.sv
// Shared constants, types and the controller/datapath command and status bundles.
`default_nettype none

package lztsd_pkg;

  // History depth must be a power of two: addresses wrap on the low bits.
  localparam int unsigned HISTORY_DEPTH    = 65536;
  localparam int unsigned HIST_AW          = $clog2(HISTORY_DEPTH);
  localparam int unsigned BYTES_PER_RESULT = 4;
  localparam int unsigned LANES            = 4;
  localparam int unsigned LANE_GROUP       = (BYTES_PER_RESULT < LANES) ? BYTES_PER_RESULT : LANES;
  localparam int unsigned LANE_CNT_W       = 3;
  localparam int unsigned LANE_IDX_W       = 2;

  localparam logic [7:0]  ESCAPE_BYTE      = 8'hFE;
  localparam logic [7:0]  ESCAPED_LIT_MARK = 8'h00;
  localparam logic [31:0] MAX_OUT_RESET    = 32'hFFFF_FFFF;

  // Register word index on the configuration port.
  localparam logic        REG_MAX_OUT      = 1'b0;

  typedef struct packed {
    logic capture;     // latch the accepted input item
    logic eval;        // decode the held item and apply its effect
    logic rd;          // issue a history read for the next copy byte
    logic cp_push;     // write the read byte to history and the lane buffer
    logic flush;       // move the lane buffer into the output register
    logic final_flush; // the flush closes the item
  } cmd_t;

  typedef struct packed {
    logic is_last;     // held item carries the last flag
    logic ev_emit;     // item emits a literal or detects an error
    logic ev_copy;     // item starts a copy of nonzero length
    logic cp_last;     // the copy byte in flight is the final one
    logic lanes_full;  // one more byte fills the lane group
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

FILE: design/lz77_token_stream_decoder.sv
// Top level of the LZ77 token stream decoder: config register, controller and datapath.
`default_nettype none

// Channel    | Dir | Handshake               | Payload
// s_*        | in  | s_tvalid / s_tready     | tdata: in_byte; tlast: in_last
// m_*        | out | m_tvalid / m_tready     | tdata: lanes, lane_count, total_length;
//            |     |                         | tlast: run_end; tuser: decode_error, stream_done
// APB        | in  | psel, penable, pready=1 | word 0: max_output_bytes
//
// A literal item is accepted, decoded and flushed; a silent item is accepted and decoded only.
// A copy of length L runs a read and a write step per byte and a flush per result: each copied
// byte is a registered history read followed by its write, so overlapping copies work.
// Reset (rst, synchronous) clears the parser, counters and output register, not history.
// A stalled m_tready holds the result and the sequencer at its flush step; a new
// input item is taken only after the previous item's last result is registered.

module lz77_token_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // in_last
  // result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [71:0] m_tdata,   // [7:0] lane_byte_0, [15:8] lane_byte_1,
                                      // [23:16] lane_byte_2, [31:24] lane_byte_3,
                                      // [34:32] lane_count, [66:35] total_length, rest 0
  output      logic        m_tlast,   // run_end
  output      logic [1:0]  m_tuser,   // [0] decode_error, [1] stream_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  lztsd_pkg::cmd_t    cmd;
  lztsd_pkg::status_t st;

  logic [31:0]                      max_out;
  logic [7:0]                       out_lane [lztsd_pkg::LANES];
  logic [lztsd_pkg::LANE_CNT_W-1:0] out_count;
  logic                             out_error;
  logic                             out_run_end;
  logic                             out_done;
  logic [31:0]                      out_total;

  // Configuration: one word register, decoded on the word index only.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lztsd_pkg::REG_MAX_OUT) ? max_out : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= lztsd_pkg::MAX_OUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lztsd_pkg::REG_MAX_OUT) begin
      max_out <= pwdata;
    end
  end

  lztsd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  lztsd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .max_out    (max_out),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_lane   (out_lane),
    .out_count  (out_count),
    .out_error  (out_error),
    .out_run_end(out_run_end),
    .out_done   (out_done),
    .out_total  (out_total)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {5'd0, out_total, out_count, out_lane[3], out_lane[2], out_lane[1],
                    out_lane[0]};
  assign m_tlast = out_run_end;
  assign m_tuser = {out_done, out_error};

  // One item at a time: no second accept right after the first.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is still in work");

  // The stream-closing result is always the final one of its item.
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("stream_done on a non-final result");

  // Errors are reported only on an item's final result.
  a_err_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("decode_error on a non-final result");

  // Total length is zero unless the stream closes here.
  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[66:35] == 32'd0))
    else $error("total_length set outside stream end");

  // Intermediate results are always full lane groups.
  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |->
      (m_tdata[34:32] == lztsd_pkg::LANE_CNT_W'(lztsd_pkg::LANE_GROUP)))
    else $error("partial lane group before the final result");

endmodule

`default_nettype wire

FILE: design/lztsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lztsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/lztsd_ctrl.sv
// Sequencing state machine: accepts an item, decodes it, runs copies, flushes results.
`default_nettype none

module lztsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire lztsd_pkg::status_t st,
  output      lztsd_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_COPY_RD,
    S_COPY_WR,
    S_FLUSH_MID,
    S_FLUSH_END
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.ev_copy) begin
          state_next = S_COPY_RD;
        end else if (st.ev_emit || st.is_last) begin
          state_next = S_FLUSH_END;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COPY_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.cp_push = 1'b1;
        if (st.cp_last) begin
          state_next = S_FLUSH_END;
        end else if (st.lanes_full) begin
          state_next = S_FLUSH_MID;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_FLUSH_MID: begin
        if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_FLUSH_END: begin
        if (st.out_free) begin
          cmd.flush       = 1'b1;
          cmd.final_flush = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/lztsd_datapath.sv
// Token parser registers, history RAM, lane buffer and output register.
`default_nettype none

module lztsd_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lztsd_pkg::cmd_t                 cmd,
  output      lztsd_pkg::status_t              st,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            in_last,
  input  wire logic [31:0]                     max_out,
  input  wire logic                            out_ready,
  output      logic                            out_valid,
  output      logic [7:0]                      out_lane [lztsd_pkg::LANES],
  output      logic [lztsd_pkg::LANE_CNT_W-1:0] out_count,
  output      logic                            out_error,
  output      logic                            out_run_end,
  output      logic                            out_done,
  output      logic [31:0]                     out_total
);

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_ESC,
    PH_DHI,
    PH_DLO
  } phase_t;

  localparam int unsigned AW = lztsd_pkg::HIST_AW;
  localparam logic [16:0] HIST_DEPTH_17 = 17'(lztsd_pkg::HISTORY_DEPTH);

  // Held item and parser state
  logic [7:0]  byte_q;
  logic        last_q;
  phase_t      phase;
  logic [7:0]  dist_hi;
  logic [7:0]  dist_lo;
  logic [31:0] prod;
  logic        failed;
  logic        item_err;
  logic [7:0]  remaining;

  // Lane buffer
  logic [7:0]                      lane [lztsd_pkg::LANES];
  logic [lztsd_pkg::LANE_CNT_W-1:0] lane_cnt;

  // Decode results
  phase_t      phase_next;
  logic        ev_err;
  logic        ev_lit;
  logic        ev_copy;
  logic [7:0]  lit_val;
  logic        load_hi;
  logic        load_lo;
  logic [15:0] copy_dist;
  logic        dist_bad;
  logic [31:0] room;

  // History port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          push;
  logic [7:0]    push_byte;
  logic          stream_end;

  assign copy_dist = {dist_hi, dist_lo};
  assign dist_bad  = (copy_dist == 16'd0) || ({16'd0, copy_dist} > prod) ||
                     ({1'b0, copy_dist} > HIST_DEPTH_17);
  assign room      = (max_out > prod) ? (max_out - prod) : 32'd0;

  always_comb begin
    phase_next = phase;
    ev_err     = 1'b0;
    ev_lit     = 1'b0;
    ev_copy    = 1'b0;
    lit_val    = byte_q;
    load_hi    = 1'b0;
    load_lo    = 1'b0;
    if (!failed) begin
      unique case (phase)
        PH_TOKEN: begin
          if (byte_q == lztsd_pkg::ESCAPE_BYTE && !last_q) begin
            phase_next = PH_ESC;
          end else if (room == 32'd0) begin
            ev_err = 1'b1;
          end else begin
            ev_lit = 1'b1;
          end
        end
        PH_ESC: begin
          if (byte_q == lztsd_pkg::ESCAPED_LIT_MARK) begin
            phase_next = PH_TOKEN;
            lit_val    = lztsd_pkg::ESCAPE_BYTE;
            if (room == 32'd0) begin
              ev_err = 1'b1;
            end else begin
              ev_lit = 1'b1;
            end
          end else if (last_q) begin
            ev_err = 1'b1;
          end else begin
            load_hi    = 1'b1;
            phase_next = PH_DHI;
          end
        end
        PH_DHI: begin
          if (last_q) begin
            ev_err = 1'b1;
          end else begin
            load_lo    = 1'b1;
            phase_next = PH_DLO;
          end
        end
        PH_DLO: begin
          phase_next = PH_TOKEN;
          if (dist_bad || ({24'd0, byte_q} > room)) begin
            ev_err = 1'b1;
          end else begin
            ev_copy = (byte_q != 8'd0);
          end
        end
        default: phase_next = PH_TOKEN;
      endcase
    end
  end

  assign st.is_last    = last_q;
  assign st.ev_emit    = ev_err || ev_lit;
  assign st.ev_copy    = ev_copy;
  assign st.cp_last    = (remaining == 8'd1);
  assign st.lanes_full = (lane_cnt == lztsd_pkg::LANE_CNT_W'(lztsd_pkg::LANE_GROUP - 1));
  assign st.out_free   = !out_valid || out_ready;

  // One write source per cycle: a literal during decode or a copy byte.
  assign push      = (cmd.eval && ev_lit) || cmd.cp_push;
  assign push_byte = cmd.cp_push ? ram_rdata : lit_val;
  assign ram_we    = push;
  assign ram_waddr = prod[AW-1:0];
  assign ram_wdata = push_byte;
  assign ram_raddr = prod[AW-1:0] - copy_dist[AW-1:0];

  assign stream_end = cmd.flush && cmd.final_flush && last_q;

  lztsd_ram #(
    .WIDTH(8),
    .DEPTH(lztsd_pkg::HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TOKEN;
      dist_hi   <= 8'd0;
      dist_lo   <= 8'd0;
      prod      <= 32'd0;
      failed    <= 1'b0;
      item_err  <= 1'b0;
      remaining <= 8'd0;
      lane_cnt  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < lztsd_pkg::LANES; i++) begin
        lane[i] <= 8'd0;
      end
    end else begin
      if (cmd.capture) begin
        byte_q   <= in_byte;
        last_q   <= in_last;
        item_err <= 1'b0;
      end
      if (cmd.eval) begin
        phase <= phase_next;
        if (load_hi) begin
          dist_hi <= byte_q;
        end
        if (load_lo) begin
          dist_lo <= byte_q;
        end
        if (ev_err) begin
          failed   <= 1'b1;
          item_err <= 1'b1;
        end
        if (ev_copy) begin
          remaining <= byte_q;
        end
      end
      if (push) begin
        lane[lane_cnt[lztsd_pkg::LANE_IDX_W-1:0]] <= push_byte;
        lane_cnt <= lane_cnt + lztsd_pkg::LANE_CNT_W'(1);
        prod     <= prod + 32'd1;
      end
      if (cmd.cp_push) begin
        remaining <= remaining - 8'd1;
      end

      if (cmd.flush) begin
        out_valid   <= 1'b1;
        out_lane    <= lane;
        out_count   <= lane_cnt;
        out_error   <= cmd.final_flush && (item_err || (last_q && failed));
        out_run_end <= cmd.final_flush;
        out_done    <= cmd.final_flush && last_q;
        out_total   <= (cmd.final_flush && last_q) ? prod : 32'd0;
        lane_cnt    <= '0;
        for (int i = 0; i < lztsd_pkg::LANES; i++) begin
          lane[i] <= 8'd0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Stream closes: drop all parser state back to its start.
      if (stream_end) begin
        phase   <= PH_TOKEN;
        dist_hi <= 8'd0;
        dist_lo <= 8'd0;
        prod    <= 32'd0;
        failed  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
